// ----- hdl/m4inv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared types and widths for the 4x4 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package m4inv_pkg;

	localparam int ELEM_COUNT = 16;
	localparam int ELEM_W     = 32;
	localparam int ADDR_W     = 4;
	localparam int Q_BITS     = 32;

	// cofactor magnitude < 2^96, product of cofactor and element < 2^128
	localparam int MW = 96;
	localparam int PW = 128;
	// signed accumulator for cofactor and determinant (|det| < 2^129)
	localparam int AW = 131;
	// divider datapath: holds dabs << 33 and the scaled cofactor
	localparam int DW = 164;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_MSET,
		ST_MUL,
		ST_MFIN,
		ST_CEND,
		ST_DRD,
		ST_DEND,
		ST_QSET,
		ST_QRUN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_FIRST,
		OP_SECOND,
		OP_DET
	} mul_op_t;

	typedef enum logic {
		PH_DET,
		PH_OUT
	} phase_t;

	typedef struct packed {
		logic              start;
		logic [MW-1:0]     mag;
		logic [ELEM_W-1:0] mpl;
	} mul_req_t;

	typedef struct packed {
		logic          start;
		logic [DW-1:0] rem;
		logic [DW-1:0] dsh;
	} div_req_t;

endpackage

// ----- hdl/m4inv_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_store
// 16 x 32 element store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module m4inv_store (
	input  logic                                clk,
	input  logic                                we,
	input  logic [m4inv_pkg::ADDR_W-1:0]        waddr,
	input  logic [m4inv_pkg::ELEM_W-1:0]        wdata,
	input  logic [m4inv_pkg::ADDR_W-1:0]        raddr,
	output logic [m4inv_pkg::ELEM_W-1:0]        rdata
);

	logic [m4inv_pkg::ELEM_W-1:0] mem [m4inv_pkg::ELEM_COUNT];
	logic [m4inv_pkg::ELEM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/m4inv_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module m4inv_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  m4inv_pkg::mul_req_t           req,
	output logic                          done,
	output logic [m4inv_pkg::PW-1:0]      prod
);

	logic [m4inv_pkg::MW-1:0]     mag_q;
	logic [m4inv_pkg::ELEM_W-1:0] mpl_q;
	logic [m4inv_pkg::PW-1:0]     prod_q;
	logic [4:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [m4inv_pkg::PW-1:0]     addend;

	assign addend = mpl_q[m4inv_pkg::ELEM_W-1] ? m4inv_pkg::PW'(mag_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q  <= req.mag;
			mpl_q  <= req.mpl;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[m4inv_pkg::PW-2:0], 1'b0} + addend;
			mpl_q  <= {mpl_q[m4inv_pkg::ELEM_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ----- hdl/m4inv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_div
// Restoring divider, one quotient bit per cycle, with a range check that
// flags a quotient of 2^32 or more.
// ----------------------------------------------------------------------------
module m4inv_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  m4inv_pkg::div_req_t               req,
	output logic                              done,
	output logic                              ovf,
	output logic [m4inv_pkg::Q_BITS-1:0]      quo
);

	logic [m4inv_pkg::DW-1:0]     rem_q;
	logic [m4inv_pkg::DW-1:0]     dsh_q;
	logic [m4inv_pkg::Q_BITS-1:0] quo_q;
	logic                         ovf_q;
	logic                         busy_q;
	logic                         chk_q;
	logic                         done_q;
	logic [4:0]                   cnt_q;
	logic [m4inv_pkg::DW:0]       diff;
	logic                         ge;

	assign diff = {1'b0, rem_q} - {1'b0, dsh_q};
	assign ge   = !diff[m4inv_pkg::DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				chk_q  <= 1'b1;
			end else if (busy_q) begin
				if (chk_q) begin
					chk_q <= 1'b0;
					cnt_q <= 5'd31;
					if (ge) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			dsh_q <= req.dsh;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			if (chk_q) begin
				ovf_q <= ge;
				dsh_q <= dsh_q >> 1;
			end else begin
				if (ge) begin
					rem_q <= diff[m4inv_pkg::DW-1:0];
				end
				quo_q <= {quo_q[m4inv_pkg::Q_BITS-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = quo_q;

endmodule

// ----- hdl/matrix4_inverse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_inverse
// 4x4 signed fixed-point matrix inverse by adjugate over determinant.
//
// channel  dir  tdata                                  tuser                tlast
// s_*      in   [31:0] element_value                   -                    -
// m_*      out  [31:0] inverse_value, [35:32] index    [0] singular,        last
//                                                      [1] saturated
//
// Loading accepts one element per cycle. After the sixteenth element the
// block is busy on the bit-serial multiplier: 3x3 cofactors are summed term
// by term, 20 in all (only the 4 of the determinant when singular).
// Each result then goes through the serial divider.
// s_tready is low while computing; each result waits in the output register
// until taken. Reset clears the control state only, not the datapath.
// ----------------------------------------------------------------------------
module matrix4_inverse #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] element_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] inverse_value, [35:32] element_index
	output logic [1:0]  m_tuser,   // [0] singular, [1] saturated
	output logic        m_tlast
);

	localparam logic [2:0] TERM_LAST = 3'd5;
	localparam logic [2:0] TERM_NEG  = 3'd3;
	localparam logic [1:0] COL_LAST  = 2'd3;
	localparam logic [3:0] ELEM_LAST = 4'(m4inv_pkg::ELEM_COUNT - 1);
	localparam int         CSHIFT    = 2 * FRAC_BITS + 1;

	m4inv_pkg::state_t  state_q, state_d;
	m4inv_pkg::phase_t  phase_q;
	m4inv_pkg::mul_op_t opn_q;
	m4inv_pkg::mul_req_t mreq;
	m4inv_pkg::div_req_t dreq;

	logic [3:0]  load_q;
	logic [2:0]  t_q;
	logic [1:0]  j_q;
	logic [3:0]  k_q;
	logic [31:0] e0_q, e1_q, e2_q;
	logic        neg_q;
	logic signed [m4inv_pkg::AW-1:0] acc_q, det_q;
	logic [m4inv_pkg::MW-1:0]   cmag_q;
	logic                       cs_q;
	logic [m4inv_pkg::AW-1:0]   dabs_q;
	logic                       dneg_q;
	logic                       sing_q;
	logic [31:0]                oval_q;
	logic                       osat_q;

	logic [3:0]  raddr;
	logic [31:0] rdata;
	logic        mul_done;
	logic [m4inv_pkg::PW-1:0] prod;
	logic        div_done;
	logic        div_ovf;
	logic [31:0] quo;

	logic [1:0]  sr, sc;
	logic [m4inv_pkg::AW-1:0] acc_abs, det_abs, pext;
	logic        qneg;

	function automatic logic [31:0] abs32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [1:0] skip_sel(input logic [1:0] i, input logic [1:0] skip);
		return (i < skip) ? i : i + 2'd1;
	endfunction

	// column position of each row in term t of the 3x3 expansion
	function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] pos);
		logic [5:0] p;
		unique case (t)
			3'd0:    p = 6'b10_01_00;
			3'd1:    p = 6'b00_10_01;
			3'd2:    p = 6'b01_00_10;
			3'd3:    p = 6'b01_10_00;
			3'd4:    p = 6'b00_01_10;
			3'd5:    p = 6'b10_00_01;
			default: p = 6'b10_01_00;
		endcase
		return p[2*pos +: 2];
	endfunction

	function automatic logic [3:0] term_addr(input logic [2:0] t, input logic [1:0] pos,
		input logic [1:0] skr, input logic [1:0] skc);
		return {skip_sel(pos, skr), skip_sel(perm_col(t, pos), skc)};
	endfunction

	assign sr = (phase_q == m4inv_pkg::PH_DET) ? 2'd0 : k_q[1:0];
	assign sc = (phase_q == m4inv_pkg::PH_DET) ? j_q : k_q[3:2];

	assign acc_abs = acc_q[m4inv_pkg::AW-1] ? (~acc_q + 1'b1) : acc_q;
	assign det_abs = det_q[m4inv_pkg::AW-1] ? (~det_q + 1'b1) : det_q;
	assign pext    = m4inv_pkg::AW'(prod);
	assign qneg    = cs_q ^ dneg_q;

	m4inv_store u_store (
		.clk   (clk),
		.we    (s_tvalid && s_tready),
		.waddr (load_q),
		.wdata (s_tdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	m4inv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.prod   (prod)
	);

	m4inv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.ovf    (div_ovf),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= m4inv_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		raddr   = '0;
		mreq    = '0;
		dreq    = '0;
		unique case (state_q)
			m4inv_pkg::ST_LOAD: begin
				if (s_tvalid && load_q == ELEM_LAST) state_d = m4inv_pkg::ST_RD0;
			end
			m4inv_pkg::ST_RD0: begin
				raddr   = term_addr(t_q, 2'd0, sr, sc);
				state_d = m4inv_pkg::ST_RD1;
			end
			m4inv_pkg::ST_RD1: begin
				raddr   = term_addr(t_q, 2'd1, sr, sc);
				state_d = m4inv_pkg::ST_RD2;
			end
			m4inv_pkg::ST_RD2: begin
				raddr   = term_addr(t_q, 2'd2, sr, sc);
				state_d = m4inv_pkg::ST_MSET;
			end
			m4inv_pkg::ST_MSET: begin
				mreq.start = 1'b1;
				mreq.mag   = m4inv_pkg::MW'(abs32(e0_q));
				mreq.mpl   = abs32(e1_q);
				state_d    = m4inv_pkg::ST_MUL;
			end
			m4inv_pkg::ST_MUL: begin
				if (mul_done) begin
					if (opn_q == m4inv_pkg::OP_FIRST) begin
						mreq.start = 1'b1;
						mreq.mag   = prod[m4inv_pkg::MW-1:0];
						mreq.mpl   = abs32(e2_q);
					end else begin
						state_d = m4inv_pkg::ST_MFIN;
					end
				end
			end
			m4inv_pkg::ST_MFIN: begin
				if (opn_q == m4inv_pkg::OP_DET) begin
					state_d = (j_q == COL_LAST) ? m4inv_pkg::ST_DEND : m4inv_pkg::ST_RD0;
				end else begin
					state_d = (t_q == TERM_LAST) ? m4inv_pkg::ST_CEND : m4inv_pkg::ST_RD0;
				end
			end
			m4inv_pkg::ST_CEND: begin
				raddr   = {2'd0, j_q};
				state_d = (phase_q == m4inv_pkg::PH_DET) ? m4inv_pkg::ST_DRD
					: m4inv_pkg::ST_QSET;
			end
			m4inv_pkg::ST_DRD: begin
				mreq.start = 1'b1;
				mreq.mag   = cmag_q;
				mreq.mpl   = abs32(rdata);
				state_d    = m4inv_pkg::ST_MUL;
			end
			m4inv_pkg::ST_DEND: begin
				state_d = (det_q == '0) ? m4inv_pkg::ST_OUT : m4inv_pkg::ST_RD0;
			end
			m4inv_pkg::ST_QSET: begin
				dreq.start = 1'b1;
				dreq.rem   = (m4inv_pkg::DW'(cmag_q) << CSHIFT) + m4inv_pkg::DW'(dabs_q);
				dreq.dsh   = m4inv_pkg::DW'(dabs_q) << (m4inv_pkg::Q_BITS + 1);
				state_d    = m4inv_pkg::ST_QRUN;
			end
			m4inv_pkg::ST_QRUN: begin
				if (div_done) state_d = m4inv_pkg::ST_OUT;
			end
			m4inv_pkg::ST_OUT: begin
				if (m_tready) begin
					if (k_q == ELEM_LAST) state_d = m4inv_pkg::ST_LOAD;
					else if (sing_q)      state_d = m4inv_pkg::ST_OUT;
					else                  state_d = m4inv_pkg::ST_RD0;
				end
			end
			default: state_d = m4inv_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
		end else if (s_tvalid && s_tready) begin
			load_q <= load_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			m4inv_pkg::ST_LOAD: begin
				if (s_tvalid && load_q == ELEM_LAST) begin
					phase_q <= m4inv_pkg::PH_DET;
					j_q     <= '0;
					t_q     <= '0;
					acc_q   <= '0;
					det_q   <= '0;
				end
			end
			m4inv_pkg::ST_RD1:  e0_q <= rdata;
			m4inv_pkg::ST_RD2:  e1_q <= rdata;
			m4inv_pkg::ST_MSET: begin
				e2_q  <= rdata;
				neg_q <= e0_q[31] ^ e1_q[31];
				opn_q <= m4inv_pkg::OP_FIRST;
			end
			m4inv_pkg::ST_MUL: begin
				if (mul_done && opn_q == m4inv_pkg::OP_FIRST) begin
					neg_q <= neg_q ^ e2_q[31];
					opn_q <= m4inv_pkg::OP_SECOND;
				end
			end
			m4inv_pkg::ST_MFIN: begin
				if (opn_q == m4inv_pkg::OP_DET) begin
					det_q <= neg_q ? det_q - $signed(pext) : det_q + $signed(pext);
					if (j_q != COL_LAST) begin
						j_q   <= j_q + 2'd1;
						acc_q <= '0;
						t_q   <= '0;
					end
				end else begin
					acc_q <= (neg_q ^ (t_q >= TERM_NEG)) ? acc_q - $signed(pext)
						: acc_q + $signed(pext);
					if (t_q != TERM_LAST) t_q <= t_q + 3'd1;
				end
			end
			m4inv_pkg::ST_CEND: begin
				cs_q   <= acc_q[m4inv_pkg::AW-1] ^ sr[0] ^ sc[0];
				cmag_q <= acc_abs[m4inv_pkg::MW-1:0];
			end
			m4inv_pkg::ST_DRD: begin
				neg_q <= cs_q ^ rdata[31];
				opn_q <= m4inv_pkg::OP_DET;
			end
			m4inv_pkg::ST_DEND: begin
				dneg_q  <= det_q[m4inv_pkg::AW-1];
				dabs_q  <= det_abs;
				sing_q  <= (det_q == '0);
				k_q     <= '0;
				phase_q <= m4inv_pkg::PH_OUT;
				acc_q   <= '0;
				t_q     <= '0;
				oval_q  <= '0;
				osat_q  <= 1'b0;
			end
			m4inv_pkg::ST_QRUN: begin
				if (div_done) begin
					if (!qneg) begin
						if (div_ovf || quo[31]) begin
							osat_q <= 1'b1;
							oval_q <= 32'h7FFF_FFFF;
						end else begin
							osat_q <= 1'b0;
							oval_q <= quo;
						end
					end else begin
						if (div_ovf || quo > 32'h8000_0000) begin
							osat_q <= 1'b1;
							oval_q <= 32'h8000_0000;
						end else begin
							osat_q <= 1'b0;
							oval_q <= ~quo + 32'd1;
						end
					end
				end
			end
			m4inv_pkg::ST_OUT: begin
				if (m_tready && k_q != ELEM_LAST) begin
					k_q   <= k_q + 4'd1;
					acc_q <= '0;
					t_q   <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == m4inv_pkg::ST_LOAD);
	assign m_tvalid = (state_q == m4inv_pkg::ST_OUT);
	assign m_tdata  = {4'd0, k_q, oval_q};
	assign m_tuser  = {osat_q, sing_q};
	assign m_tlast  = (k_q == ELEM_LAST);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'd0 && !m_tuser[1]))
		else $error("singular result not zero");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[35:32] == ELEM_LAST))
		else $error("last flag on wrong index");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == m4inv_pkg::ST_MUL))
		else $error("multiplier finished outside its wait state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == m4inv_pkg::ST_QRUN))
		else $error("divider finished outside its wait state");
`endif

endmodule

// ----- tb/m4inv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4inv_checker
// Watches both streams of matrix4_inverse, predicts the sixteen inverse items
// of every loaded matrix with exact wide-integer adjugate arithmetic, and
// compares each output item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module m4inv_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic [31:0] value;
		logic [3:0]  index;
		logic        singular;
		logic        saturated;
		logic        last;
	} inv_item_t;

	inv_item_t         inverse_q[$];
	logic [15:0][31:0] matrix;
	int                load_slot;

	assign pending = inverse_q.size();

	function automatic logic signed [191:0] cofactor(input logic [15:0][31:0] a, input int sr,
		input int sc);
		int                     rs[3];
		int                     cs[3];
		int                     n;
		logic signed [191:0]    m[9];
		logic signed [191:0]    d;
		n = 0;
		for (int i = 0; i < 4; i++) if (i != sr) begin rs[n] = i; n++; end
		n = 0;
		for (int i = 0; i < 4; i++) if (i != sc) begin cs[n] = i; n++; end
		for (int i = 0; i < 9; i++) m[i] = $signed(a[rs[i / 3] * 4 + cs[i % 3]]);
		d = m[0] * (m[4] * m[8] - m[5] * m[7]) - m[1] * (m[3] * m[8] - m[5] * m[6])
			+ m[2] * (m[3] * m[7] - m[4] * m[6]);
		return ((sr + sc) % 2 == 1) ? -d : d;
	endfunction

	task automatic predict_inverse(input logic [15:0][31:0] a);
		logic signed [191:0] det;
		logic signed [191:0] c;
		logic [191:0]        dabs;
		logic [191:0]        cabs;
		logic [191:0]        q;
		logic                neg;
		inv_item_t           it;
		det = 0;
		for (int j = 0; j < 4; j++) det = det + cofactor(a, 0, j) * $signed(a[j]);
		dabs = (det < 0) ? -det : det;
		for (int k = 0; k < m4inv_pkg::ELEM_COUNT; k++) begin
			it.value = '0;
			it.index = k[3:0];
			it.singular = (det == 0);
			it.saturated = 1'b0;
			it.last = (k == m4inv_pkg::ELEM_COUNT - 1);
			if (det != 0) begin
				c = cofactor(a, k % 4, k / 4);
				cabs = (c < 0) ? -c : c;
				neg = (c < 0) != (det < 0);
				q = ((cabs << 33) + dabs) / (dabs << 1);
				if (!neg) begin
					if (q > 192'h7FFF_FFFF) begin
						it.saturated = 1'b1;
						it.value = 32'h7FFF_FFFF;
					end else it.value = q[31:0];
				end else begin
					if (q > 192'h8000_0000) begin
						it.saturated = 1'b1;
						it.value = 32'h8000_0000;
					end else it.value = -q[31:0];
				end
			end
			inverse_q.push_back(it);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		inv_item_t e;
		if (!arst_n) begin
			load_slot = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				matrix[load_slot] = s_tdata;
				if (load_slot == m4inv_pkg::ELEM_COUNT - 1) begin
					load_slot = 0;
					predict_inverse(matrix);
				end else load_slot++;
			end
			if (m_tvalid && m_tready) begin
				if (inverse_q.size() == 0) begin
					$error("output item with no prediction: tdata %h", m_tdata);
					errors++;
				end else begin
					e = inverse_q.pop_front();
					if (m_tdata[31:0] !== e.value) begin
						$error("inverse_value exp %h got %h", e.value, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[35:32] !== e.index) begin
						$error("element_index exp %0d got %0d", e.index, m_tdata[35:32]);
						errors++;
					end
					if (m_tuser[0] !== e.singular) begin
						$error("singular exp %b got %b", e.singular, m_tuser[0]);
						errors++;
					end
					if (m_tuser[1] !== e.saturated) begin
						$error("saturated exp %b got %b", e.saturated, m_tuser[1]);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$error("last exp %b got %b", e.last, m_tlast);
						errors++;
					end
				end
			end
		end
	end

	initial errors = 0;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for matrix4_inverse: streams directed and random 4x4 matrices
// (general, mid-range, tiny, diagonally dominant, singular) with random
// idling on both sides; verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_off;

	matrix4_inverse DUT (.*);

	m4inv_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("matrix4_inverse regression: fail");
		$finish;
	end

	// receiver; the hold-off outlasts a full matrix computation
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready = 0;
				repeat (12000) @(negedge clk);
				hold_off = 0;
			end
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_element(input logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = v;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic send_matrix(input logic [15:0][31:0] a);
		for (int i = 0; i < m4inv_pkg::ELEM_COUNT; i++) send_element(a[i]);
	endtask

	function automatic logic [31:0] rand_signed(input int span);
		return $urandom_range(2 * span) - span;
	endfunction

	function automatic logic [15:0][31:0] random_matrix(input int kind);
		logic [15:0][31:0] a;
		bit                zero_row;
		for (int i = 0; i < 16; i++) begin
			case (kind)
				0: a[i] = $urandom;
				1: a[i] = rand_signed(1 << 18);
				2: a[i] = rand_signed(8);
				default: a[i] = (i % 5 == 0) ? 32'h0001_0000 * $urandom_range(1, 8)
					+ rand_signed(1 << 12) : rand_signed(1 << 14);
			endcase
		end
		if (kind == 4) begin
			// singular: last row copies the first or is all zero
			zero_row = $urandom_range(1);
			for (int c = 0; c < 4; c++)
				a[12 + c] = zero_row ? 32'h0 : a[c];
		end
		return a;
	endfunction

	initial begin
		logic [15:0][31:0] a;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		hold_off = 0;
		send_idle_pct = 20;
		recv_idle_pct = 82;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// upper triangular with field extremes; inverse corner is exactly -2^31
		a = '0;
		a[0] = 32'hFFFF_FFFE;
		a[5] = 32'h0001_0000;
		a[10] = 32'h0001_0000;
		a[15] = 32'h0001_0000;
		a[3] = 32'h7FFF_FFFF;
		a[6] = 32'h8000_0000;
		a[1] = 32'hFFFF_FFFF;
		send_matrix(a);

		for (int m = 0; m < 27; m++) begin
			if (m == 9) begin
				wait (pending == 0);
				send_idle_pct = 82;
				recv_idle_pct = 20;
			end
			if (m == 18) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_off = 1;
			end
			send_matrix(random_matrix(m % 5));
		end

		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("matrix4_inverse regression: pass");
		else
			$display("matrix4_inverse regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/m4inv_pkg.sv
hdl/m4inv_store.sv
hdl/m4inv_mul.sv
hdl/m4inv_div.sv
hdl/matrix4_inverse.sv
tb/m4inv_checker.sv
tb/tb.sv
